// ===== sv/clsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clsg_pkg;

  // Coordinate width of the endpoint fields
  localparam int COORD_BITS = 12;

  // Walk state widths: one extra bit for the major position running one past the end
  localparam int MAJ_W  = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 2;
  localparam int LEN_W  = COORD_BITS + 1;
  // Clip arithmetic: start + length and right/bottom edge must fit, signed
  localparam int CLIP_W = ((COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14) + 1;

  // Fixed field widths
  localparam int POS_W      = 11;
  localparam int LENGTH_W   = 12;
  localparam int COLOUR_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Clip register reset values
  localparam logic [POS_W-1:0]      CLIP_LEFT_RST   = '0;
  localparam logic [POS_W-1:0]      CLIP_TOP_RST    = '0;
  localparam logic [CFG_DATA_W-1:0] CLIP_WIDTH_RST  = CFG_DATA_W'(319);
  localparam logic [CFG_DATA_W-1:0] CLIP_HEIGHT_RST = CFG_DATA_W'(479);

  typedef enum logic {
    OP_START_LINE = 1'b0,
    OP_NEXT_SPAN  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_WIDTH  = 2'd2,
    CFG_CLIP_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [MAJ_W-1:0]      major_t;
  typedef logic        [MAJ_W-1:0]      delta_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic signed [CLIP_W-1:0]     clip_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;      // latch endpoints and colour of a start_line
    logic setup_a;      // absolute deltas and steep decision
    logic setup_b;      // orient endpoints, load walk state
    logic span_begin;   // open a run at the current position
    logic walk_step;    // one Bresenham step
    logic result_load;  // clip the run and load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic line_active;
    logic step_done;    // current walk step closes the run
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/clsg_line_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface clsg_line_if import clsg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  coord_t                x_start;
  coord_t                y_start;
  coord_t                x_end;
  coord_t                y_end;
  logic [COLOUR_W-1:0]   colour;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, colour,
                  input ready);
  modport sink   (input valid, operation, x_start, y_start, x_end, y_end, colour,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/clsg_span_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface clsg_span_if import clsg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [POS_W-1:0]      span_x;
  logic [POS_W-1:0]      span_y;
  logic [LENGTH_W-1:0]   span_length;
  logic                  vertical;
  logic                  visible;
  logic [COLOUR_W-1:0]   span_colour;
  logic                  last;

  modport source (output valid, span_x, span_y, span_length, vertical, visible,
                  span_colour, last, input ready);
  modport sink   (input valid, span_x, span_y, span_length, vertical, visible,
                  span_colour, last, output ready);
endinterface

`default_nettype wire

// ===== sv/clsg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clsg_ctrl import clsg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_operation,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_WALK,
    ST_CLIP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xact;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xact   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xact) begin
          if (in_operation == OP_START_LINE) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_SETUP_A;
          end else if (stat.line_active) begin
            cmd.span_begin = 1'b1;
            state_nxt      = ST_WALK;
          end
        end
      end
      ST_SETUP_A: begin
        cmd.setup_a = 1'b1;
        state_nxt   = ST_SETUP_B;
      end
      ST_SETUP_B: begin
        cmd.setup_b = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.step_done) state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        // hold the finished run until the output register frees up
        if (slot_free) begin
          cmd.result_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register is never overwritten while a transaction is pending
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transaction");

  // Setup A is always followed by setup B
  a_setup_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.setup_a |=> cmd.setup_b)
    else $error("setup sequence broken");

  // A run only starts on an active line
  a_span_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.span_begin |-> stat.line_active)
    else $error("run started without an active line");

  // A new result always comes from a clip-and-load cycle
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.result_load))
    else $error("output valid raised without a load");

endmodule

`default_nettype wire

// ===== sv/clsg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clsg_datapath import clsg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input payload
  input  wire coord_t                in_x_start,
  input  wire coord_t                in_y_start,
  input  wire coord_t                in_x_end,
  input  wire coord_t                in_y_end,
  input  wire logic [COLOUR_W-1:0]   in_colour,
  // result payload
  output logic [POS_W-1:0]           out_span_x,
  output logic [POS_W-1:0]           out_span_y,
  output logic [LENGTH_W-1:0]        out_span_length,
  output logic                       out_vertical,
  output logic                       out_visible,
  output logic [COLOUR_W-1:0]        out_span_colour,
  output logic                       out_last,
  // control
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat
);

  // Clip rectangle
  logic [POS_W-1:0]      clip_left_r, clip_top_r;
  logic [CFG_DATA_W-1:0] clip_width_r, clip_height_r;

  // Captured endpoints and line attributes
  coord_t                ax_r, ay_r, bx_r, by_r;
  logic [COLOUR_W-1:0]   line_colour_r;
  delta_t                adx_r, ady_r;
  logic                  steep_r;

  // Walk state
  logic                  line_active_r;
  major_t                major_pos_r, major_end_r, minor_pos_r;
  logic                  step_down_r;
  err_t                  err_r;
  delta_t                major_delta_r, minor_delta_r;

  // Current run
  major_t                span_start_r, span_minor_r;
  logic [LEN_W-1:0]      len_r;
  logic                  last_r;

  // Result register
  logic [POS_W-1:0]      res_x_r, res_y_r;
  logic [LENGTH_W-1:0]   res_len_r;
  logic                  res_vert_r, res_vis_r, res_last_r;
  logic [COLOUR_W-1:0]   res_colour_r;

  // ---- setup A: absolute deltas ----
  major_t dx, dy;
  delta_t adx, ady;

  assign dx  = {bx_r[COORD_BITS-1], bx_r} - {ax_r[COORD_BITS-1], ax_r};
  assign dy  = {by_r[COORD_BITS-1], by_r} - {ay_r[COORD_BITS-1], ay_r};
  assign adx = dx[MAJ_W-1] ? delta_t'(-dx) : delta_t'(dx);
  assign ady = dy[MAJ_W-1] ? delta_t'(-dy) : delta_t'(dy);

  // ---- setup B: swap axes for steep lines, order along the major axis ----
  coord_t sax, say, sbx, sby;
  logic   swap;
  coord_t o_maj0, o_maj1, o_min0, o_min1;
  delta_t maj_d, min_d;

  assign sax    = steep_r ? ay_r : ax_r;
  assign say    = steep_r ? ax_r : ay_r;
  assign sbx    = steep_r ? by_r : bx_r;
  assign sby    = steep_r ? bx_r : by_r;
  assign swap   = sax > sbx;
  assign o_maj0 = swap ? sbx : sax;
  assign o_maj1 = swap ? sax : sbx;
  assign o_min0 = swap ? sby : say;
  assign o_min1 = swap ? say : sby;
  assign maj_d  = steep_r ? ady_r : adx_r;
  assign min_d  = steep_r ? adx_r : ady_r;

  // ---- one Bresenham step ----
  err_t err_sub;
  logic minor_move, at_end;

  assign err_sub    = err_r - $signed({1'b0, minor_delta_r});
  assign minor_move = err_sub[ERR_W-1];
  assign at_end     = (major_pos_r == major_end_r);

  assign stat.line_active = line_active_r;
  assign stat.step_done   = minor_move || at_end;

  // ---- clip the finished run ----
  clip_t along, across, run_end, c_left, c_top, c_right, c_bottom;
  clip_t lo_a, hi_a, lo_c, hi_c, a_clip, e_clip, c_len;
  logic  vis_pre, vis;

  assign along    = clip_t'(span_start_r);
  assign across   = clip_t'(span_minor_r);
  assign run_end  = along + clip_t'({1'b0, len_r});
  assign c_left   = clip_t'({1'b0, clip_left_r});
  assign c_top    = clip_t'({1'b0, clip_top_r});
  assign c_right  = c_left + clip_t'({1'b0, clip_width_r});
  assign c_bottom = c_top + clip_t'({1'b0, clip_height_r});
  assign lo_a     = steep_r ? c_top : c_left;
  assign hi_a     = steep_r ? c_bottom : c_right;
  assign lo_c     = steep_r ? c_left : c_top;
  assign hi_c     = steep_r ? c_right : c_bottom;
  assign vis_pre  = !(across < lo_c || across >= hi_c || along >= hi_a);
  assign a_clip   = (along < lo_a) ? lo_a : along;
  assign e_clip   = (run_end > hi_a) ? hi_a : run_end;
  assign c_len    = e_clip - a_clip;
  assign vis      = vis_pre && (c_len > clip_t'(0));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= CLIP_LEFT_RST;
      clip_top_r    <= CLIP_TOP_RST;
      clip_width_r  <= CLIP_WIDTH_RST;
      clip_height_r <= CLIP_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CLIP_LEFT:   clip_left_r   <= cfg_data[POS_W-1:0];
        CFG_CLIP_TOP:    clip_top_r    <= cfg_data[POS_W-1:0];
        CFG_CLIP_WIDTH:  clip_width_r  <= cfg_data;
        CFG_CLIP_HEIGHT: clip_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line active flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else if (cmd.setup_b) begin
      line_active_r <= 1'b1;
    end else if (cmd.walk_step && stat.step_done && (at_end || !minor_move || at_end)) begin
      // run closes either on a minor move at the end point or at the end point itself
      if (at_end) line_active_r <= 1'b0;
    end
  end

  // Line setup and walk state
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax_r          <= in_x_start;
      ay_r          <= in_y_start;
      bx_r          <= in_x_end;
      by_r          <= in_y_end;
      line_colour_r <= in_colour;
    end
    if (cmd.setup_a) begin
      adx_r   <= adx;
      ady_r   <= ady;
      steep_r <= ady > adx;
    end
    if (cmd.setup_b) begin
      major_pos_r   <= major_t'(o_maj0);
      major_end_r   <= major_t'(o_maj1);
      minor_pos_r   <= major_t'(o_min0);
      step_down_r   <= o_min0 < o_min1;
      major_delta_r <= maj_d;
      minor_delta_r <= min_d;
      err_r         <= err_t'({1'b0, maj_d >> 1});
    end
    if (cmd.span_begin) begin
      span_start_r <= major_pos_r;
      span_minor_r <= minor_pos_r;
      len_r        <= '0;
    end
    if (cmd.walk_step) begin
      len_r <= len_r + LEN_W'(1);
      if (minor_move) begin
        minor_pos_r <= step_down_r ? minor_pos_r + major_t'(1) : minor_pos_r - major_t'(1);
        err_r       <= err_sub + $signed({1'b0, major_delta_r});
        major_pos_r <= major_pos_r + major_t'(1);
        last_r      <= at_end;
      end else if (at_end) begin
        err_r  <= err_sub;
        last_r <= 1'b1;
      end else begin
        err_r       <= err_sub;
        major_pos_r <= major_pos_r + major_t'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_vis_r    <= vis;
      res_x_r      <= vis ? (steep_r ? across[POS_W-1:0] : a_clip[POS_W-1:0]) : '0;
      res_y_r      <= vis ? (steep_r ? a_clip[POS_W-1:0] : across[POS_W-1:0]) : '0;
      res_len_r    <= vis ? c_len[LENGTH_W-1:0] : '0;
      res_vert_r   <= steep_r;
      res_colour_r <= line_colour_r;
      res_last_r   <= last_r;
    end
  end

  assign out_span_x      = res_x_r;
  assign out_span_y      = res_y_r;
  assign out_span_length = res_len_r;
  assign out_vertical    = res_vert_r;
  assign out_visible     = res_vis_r;
  assign out_span_colour = res_colour_r;
  assign out_last        = res_last_r;

endmodule

`default_nettype wire

// ===== sv/clipped_line_span_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Transaction
// in_line   in   start_line (endpoints, colour) or next_span request
// out_span  out  one clipped run: position, length, direction, colour, marks
// cfg_*     in   clip rectangle register write, no read-back
//
// start_line: accepted, then setup states SETUP_A and SETUP_B; produces no result.
// next_span: accept, then a walk over the L pixels of the run, then clip/load; L = run length
//   in pixels (1 .. 2^COORD_BITS); the walk does one Bresenham step per cycle.
// A next_span with no active line is dropped in its accept cycle.
// Reset (rst_n low, synchronous): no line active, output empty, clip = 0,0,319,479.
// A result waits in the output register; the next request is taken meanwhile and
//   holds in its clip cycle until the register is free.
module clipped_line_span_generator import clsg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  clsg_line_if.sink                  in_line,
  clsg_span_if.source                out_span
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing
  clsg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_line.valid),
    .in_operation (in_line.operation),
    .in_ready     (in_line.ready),
    .out_valid    (out_span.valid),
    .out_ready    (out_span.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Setup, walk, clip and result register
  clsg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_x_start      (in_line.x_start),
    .in_y_start      (in_line.y_start),
    .in_x_end        (in_line.x_end),
    .in_y_end        (in_line.y_end),
    .in_colour       (in_line.colour),
    .out_span_x      (out_span.span_x),
    .out_span_y      (out_span.span_y),
    .out_span_length (out_span.span_length),
    .out_vertical    (out_span.vertical),
    .out_visible     (out_span.visible),
    .out_span_colour (out_span.span_colour),
    .out_last        (out_span.last),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

`default_nettype wire

// ===== bench/clsg_span_checker.sv =====
`timescale 1ns / 1ps

// Watches the line and span channels and the clip register port, predicts
// every run a next_span request causes and compares it with the span channel.
module clsg_span_checker import clsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  clsg_line_if                  line_mon,
  clsg_span_if                  span_mon,
  output int                    fail_count,
  output int                    pending,
  output int                    spans_checked
);

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [LENGTH_W-1:0] length;
    logic                vertical;
    logic                visible;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } span_t;

  // Clip rectangle copy
  logic [POS_W-1:0]      win_left, win_top;
  logic [CFG_DATA_W-1:0] win_width, win_height;

  // Walk state copy
  bit                  line_live, is_steep, walk_down;
  int                  walk_pos, walk_end, cross_pos, bres_err;
  int                  long_delta, short_delta, run_origin;
  logic [COLOUR_W-1:0] held_colour;

  span_t due_spans[$];
  span_t want;
  int    errors;
  int    compared;

  function automatic int absval(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp_val));
  endtask

  // start_line: orient endpoints along the major axis and set up the walk
  task automatic load_walk(coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                           logic [COLOUR_W-1:0] col);
    int ax, ay, bx, by, t;
    ax = xs;
    ay = ys;
    bx = xe;
    by = ye;
    is_steep = absval(by - ay) > absval(bx - ax);
    if (is_steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    long_delta  = bx - ax;
    short_delta = absval(by - ay);
    bres_err    = long_delta >>> 1;
    walk_down   = ay < by;
    walk_pos    = ax;
    walk_end    = bx;
    cross_pos   = ay;
    run_origin  = ax;
    held_colour = col;
    line_live   = 1'b1;
  endtask

  // next_span: walk until the minor coordinate moves or the line ends, then clip
  function automatic span_t walk_next_run();
    span_t s;
    int    origin, minor, len, l, tp, r, b, rx, ry, rlen;
    bit    done, vis;
    origin = run_origin;
    minor  = cross_pos;
    len    = 0;
    done   = 1'b0;
    s.last = 1'b0;
    while (!done) begin
      len++;
      bres_err -= short_delta;
      if (bres_err < 0) begin
        s.last     = (walk_pos == walk_end);
        cross_pos += walk_down ? 1 : -1;
        bres_err  += long_delta;
        walk_pos++;
        run_origin = walk_pos;
        done       = 1'b1;
      end else if (walk_pos == walk_end) begin
        s.last = 1'b1;
        done   = 1'b1;
      end else begin
        walk_pos++;
      end
    end
    if (s.last)
      line_live = 1'b0;

    l  = win_left;
    tp = win_top;
    r  = l + int'(win_width);
    b  = tp + int'(win_height);
    if (!is_steep) begin
      rx = origin; ry = minor; rlen = len;
      vis = !(ry < tp || rx >= r || ry >= b);
      if (vis) begin
        if (rx < l) begin
          rlen += rx - l;
          rx = l;
        end
        if (rx + rlen > r) rlen = r - rx;
        vis = rlen >= 1;
      end
    end else begin
      rx = minor; ry = origin; rlen = len;
      vis = !(rx < l || rx >= r || ry >= b);
      if (vis) begin
        if (ry < tp) begin
          rlen += ry - tp;
          ry = tp;
        end
        if (ry + rlen > b) rlen = b - ry;
        vis = rlen >= 1;
      end
    end
    if (!vis) begin
      rx = 0; ry = 0; rlen = 0;
    end
    s.x        = rx[POS_W-1:0];
    s.y        = ry[POS_W-1:0];
    s.length   = rlen[LENGTH_W-1:0];
    s.vertical = is_steep;
    s.visible  = vis;
    s.colour   = held_colour;
    return s;
  endfunction

  // Sample both channels and the register port at every rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      win_left    = CLIP_LEFT_RST;
      win_top     = CLIP_TOP_RST;
      win_width   = CLIP_WIDTH_RST;
      win_height  = CLIP_HEIGHT_RST;
      line_live   = 1'b0;
      is_steep    = 1'b0;
      walk_down   = 1'b0;
      walk_pos    = 0;
      walk_end    = 0;
      cross_pos   = 0;
      bres_err    = 0;
      long_delta  = 0;
      short_delta = 0;
      run_origin  = 0;
      held_colour = '0;
      due_spans.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CLIP_LEFT:   win_left   = cfg_data[POS_W-1:0];
          CFG_CLIP_TOP:    win_top    = cfg_data[POS_W-1:0];
          CFG_CLIP_WIDTH:  win_width  = cfg_data;
          CFG_CLIP_HEIGHT: win_height = cfg_data;
          default: ;
        endcase
      end

      // input transaction: load a line or predict the next run
      if (line_mon.valid && line_mon.ready) begin
        if (line_mon.operation == OP_START_LINE)
          load_walk(line_mon.x_start, line_mon.y_start, line_mon.x_end, line_mon.y_end,
                    line_mon.colour);
        else if (line_live)
          due_spans.push_back(walk_next_run());
      end

      // output transaction: compare with the oldest prediction
      if (span_mon.valid && span_mon.ready) begin
        if (due_spans.size() == 0) begin
          report_mismatch("span transaction with no run predicted");
        end else begin
          want = due_spans.pop_front();
          compared++;
          check_field("span_x",      span_mon.span_x,      want.x);
          check_field("span_y",      span_mon.span_y,      want.y);
          check_field("span_length", span_mon.span_length, want.length);
          check_field("vertical",    span_mon.vertical,    want.vertical);
          check_field("visible",     span_mon.visible,     want.visible);
          check_field("span_colour", span_mon.span_colour, want.colour);
          check_field("last",        span_mon.last,        want.last);
        end
      end
    end
    fail_count    <= errors;
    pending       <= due_spans.size();
    spans_checked <= compared;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import clsg_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int RANDOM_ITEMS  = 290;
  localparam int MAX_REQS      = 40;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  clsg_line_if line_ch ();
  clsg_span_if span_ch ();

  int fail_count, pending, spans_checked;
  int cycle_count;
  int hold_requests;
  int burst_left;
  bit gaps_on;
  int lines_loaded, span_requests, clip_settings, items_counted;
  logic [CFG_DATA_W-1:0] cur_left, cur_top;

  clipped_line_span_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_line   (line_ch),
    .out_span  (span_ch)
  );

  clsg_span_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .line_mon      (line_ch),
    .span_mon      (span_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .spans_checked (spans_checked)
  );

  always begin
    clk = 1'b1;
    #(CLK_HALF);
    clk = 1'b0;
    #(CLK_HALF);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs still outstanding", cycle_count, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Span receiver: changing stall patterns, plus a long hold-off on request
  initial begin : rx_pacing
    rx_mode_t mode;
    int       mode_left, hold_left, holds_served, tick;
    span_ch.ready = 1'b0;
    mode          = RX_STEADY;
    mode_left     = 0;
    hold_left     = 0;
    holds_served  = 0;
    tick          = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        span_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY:   span_ch.ready <= 1'b1;
          RX_COIN:     span_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   span_ch.ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: span_ch.ready <= (tick % 4 != 0);
          default:     span_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one transaction, in bursts with random gaps between them
  task automatic offer(op_t op, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                       logic [COLOUR_W-1:0] col);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        line_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    line_ch.valid     <= 1'b1;
    line_ch.operation <= op;
    line_ch.x_start   <= xs;
    line_ch.y_start   <= ys;
    line_ch.x_end     <= xe;
    line_ch.y_end     <= ye;
    line_ch.colour    <= col;
    if (op == OP_START_LINE) lines_loaded++;
    else span_requests++;
    @(posedge clk);
    while (!line_ch.ready) @(posedge clk);
  endtask

  task automatic begin_line(int xs, int ys, int xe, int ye, logic [COLOUR_W-1:0] col);
    offer(OP_START_LINE, coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye), col);
  endtask

  // Endpoint fields are don't-care on a request, so fill them with noise
  task automatic ask_span();
    offer(OP_NEXT_SPAN, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
          coord_t'($urandom()), COLOUR_W'($urandom()));
  endtask

  // Wait until every predicted run has come out and the block is quiet
  task automatic drain();
    line_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four clip registers, one per cycle
  task automatic write_clip(logic [CFG_DATA_W-1:0] l, logic [CFG_DATA_W-1:0] t,
                            logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_CLIP_LEFT;
    cfg_data  <= l;
    @(posedge clk);
    cfg_index <= CFG_CLIP_TOP;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= CFG_CLIP_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_CLIP_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_left = l;
    cur_top  = t;
    clip_settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_extent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DATA_W'(2048);
      default: return CFG_DATA_W'($urandom_range(1, 200));
    endcase
  endfunction

  // One line near the clip window (mostly), then a run of requests for it;
  // some lines are cut short by the next load, some get surplus requests
  task automatic random_line();
    int     kind, x0, y0, dx, dy, along, across, runs, reqs, extras, ddx, ddy;
    coord_t xs, ys, xe, ye;
    kind   = $urandom_range(0, 9);
    along  = $urandom_range(0, 60);
    across = $urandom_range(0, 8);
    x0     = int'(cur_left) - 40 + $urandom_range(0, 200);
    y0     = int'(cur_top) - 40 + $urandom_range(0, 200);
    extras = 0;
    if (kind == 7) begin
      // anywhere in the coordinate range, may wrap into a long line
      x0 = $urandom_range(0, 4095);
      y0 = $urandom_range(0, 4095);
    end else if (kind == 8) begin
      // point, pure horizontal or pure vertical
      across = 0;
      along  = $urandom_range(0, 40) * $urandom_range(0, 1);
    end else if (kind == 9) begin
      along  = $urandom_range(200, 1500);
      across = $urandom_range(0, 3);
    end
    if ($urandom_range(0, 1)) begin
      dx = along;
      dy = across;
    end else begin
      dx = across;
      dy = along;
    end
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    xs = coord_t'(x0);
    ys = coord_t'(y0);
    xe = coord_t'(x0 + dx);
    ye = coord_t'(y0 + dy);

    ddx  = int'(xe) - int'(xs);
    ddy  = int'(ye) - int'(ys);
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    runs = ((ddx < ddy) ? ddx : ddy) + 1;
    reqs = (runs > MAX_REQS) ? MAX_REQS : runs;
    case ($urandom_range(0, 3))
      0:       reqs = $urandom_range(1, reqs);
      1:       extras = $urandom_range(1, 2);
      default: ;
    endcase
    items_counted += 1 + reqs;

    offer(OP_START_LINE, xs, ys, xe, ye, COLOUR_W'($urandom()));
    repeat (reqs + extras) ask_span();
  endtask

  // Stimulus and verdict
  initial begin : main
    int phase_idx, phase_target;
    logic [CFG_DATA_W-1:0] l, t, w, h;

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = CFG_CLIP_LEFT;
    cfg_data          = '0;
    line_ch.valid     = 1'b0;
    line_ch.operation = OP_START_LINE;
    line_ch.x_start   = '0;
    line_ch.y_start   = '0;
    line_ch.x_end     = '0;
    line_ch.y_end     = '0;
    line_ch.colour    = '0;
    gaps_on           = 1'b1;
    burst_left        = 0;
    cur_left          = '0;
    cur_top           = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset clip window
    ask_span();                                   // no line loaded yet: dropped
    begin_line(10, 20, 30, 25, 24'hFFFFFF);
    repeat (3) ask_span();
    begin_line(5, 5, 5, 5, 24'h000000);           // replaces the line in progress
    ask_span();                                   // single pixel, marked last
    ask_span();                                   // line finished: dropped
    begin_line(-2048, 100, 2047, 100, 24'hA5A5A5); // full-width horizontal
    ask_span();
    begin_line(100, 2047, 100, -2048, 24'h5A5A5A); // full-height vertical, reversed
    ask_span();
    begin_line(50, 60, 47, 52, 24'h123456);       // steep, walking backwards
    repeat (4) ask_span();
    begin_line(-100, -50, -90, -48, 24'h800001);  // wholly outside the window
    repeat (3) ask_span();
    begin_line(-2048, -2048, 2047, 2047, 24'h7FFFFE); // extreme diagonal, left open
    repeat (2) ask_span();

    // Random part, one clip setting per phase
    phase_idx     = 0;
    items_counted = 0;
    while (items_counted < RANDOM_ITEMS) begin
      drain();
      case (phase_idx)
        0: begin l = 0;    t = 0;    w = 0;    h = 479;  end
        1: begin l = 0;    t = 0;    w = 319;  h = 0;    end
        2: begin l = 0;    t = 0;    w = 2048; h = 2048; end
        3: begin l = 2047; t = 2047; w = 2048; h = 2048; end
        4: begin l = 2047; t = 2047; w = 1;    h = 1;    end
        default: begin
          l = $urandom_range(0, 120);
          t = $urandom_range(0, 120);
          w = pick_extent();
          h = pick_extent();
        end
      endcase
      write_clip(l, t, w, h);
      gaps_on = ($urandom_range(0, 3) != 0);
      // back up the span channel while requests keep coming
      if (phase_idx == 2) hold_requests <= hold_requests + 1;
      phase_target = items_counted + $urandom_range(20, 40);
      while (items_counted < phase_target && items_counted < RANDOM_ITEMS)
        random_line();
      phase_idx++;
    end
    drain();

    $display("covered %0d line loads and %0d span requests over %0d clip settings",
             lines_loaded, span_requests, clip_settings + 1);
    $display("%0d spans compared, %0d mismatches, %0d cycles",
             spans_checked, fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
